// File: design/lps_pkg.sv
// Shared constants, codes and types for the loopback probe sequencer.
// No dependencies; used by design/loopback_probe_sequencer.sv.
`default_nettype none

package lps_pkg;

    // Store geometry
    localparam int SWEEP_DEPTH   = 131072;
    localparam int CAPTURE_DEPTH = 262144;
    localparam int SAMPLE_BITS   = 24;

    localparam int SWEEP_AW   = (SWEEP_DEPTH > 1) ? $clog2(SWEEP_DEPTH) : 1;
    localparam int CAPTURE_AW = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
    localparam int SPOS_W     = $clog2(SWEEP_DEPTH + 1);
    localparam int CPOS_W     = $clog2(CAPTURE_DEPTH + 1);

    // Field widths of the stream payload
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 18;
    localparam int FIELD_W = 24;
    localparam int MODE_W  = 3;

    // Configuration register widths
    localparam int PRIME_W = 24;
    localparam int SLEN_W  = 18;
    localparam int CLEN_W  = 19;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_ARM   = 2'd1;
    localparam logic [OP_W-1:0] OP_FRAME = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    // Sequencer modes
    localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PRIMING  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_EMITTING = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRAILING = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DONE     = 3'd4;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_PRIME_FRAMES   = 2'd0;
    localparam logic [1:0] REG_SWEEP_LENGTH   = 2'd1;
    localparam logic [1:0] REG_CAPTURE_LENGTH = 2'd2;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [SWEEP_AW-1:0]    t_sw_idx;
    typedef logic [CAPTURE_AW-1:0]  t_cap_idx;
    typedef logic [SPOS_W-1:0]      t_spos;
    typedef logic [CPOS_W-1:0]      t_cpos;

endpackage

`default_nettype wire

// File: design/loopback_probe_sequencer.sv
// Loopback probe sequencer: sweep store, capture store and mode control.
// Depends on lps_pkg.
// Each accepted transaction passes stage 1, then the output register; one
// transaction per cycle unless output back-pressure stalls; each item makes at
// most one access to the single-port sweep memory and one to the single-port
// capture memory. Reset (synchronous, active low) clears mode, positions and
// registers. The capture store needs no clearing pass: entries at or past the
// capture position read as zero, so arm and reset empty it by clearing the position.
`default_nettype none

module loopback_probe_sequencer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // stream in
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [17:0] address, [41:18] sweep_word, [65:42] in_sample, [71:66] zero
    input  wire  [71:0] s_axis_tdata,
    // [1:0] op
    input  wire  [1:0]  s_axis_tuser,
    // stream out
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [23:0] out_sample, [47:24] capture_word, [50:48] mode, [55:51] zero
    output logic [55:0] m_axis_tdata,
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration ----------------
    logic [lps_pkg::PRIME_W-1:0] r_prime_frames;
    logic [lps_pkg::SLEN_W-1:0]  r_sweep_length;
    logic [lps_pkg::CLEN_W-1:0]  r_capture_length;
    logic                        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime_frames   <= '0;
            r_sweep_length   <= '0;
            r_capture_length <= '0;
        end else if (cfg_we) begin
            case (paddr[3:2])
                lps_pkg::REG_PRIME_FRAMES:
                    r_prime_frames <= pwdata[lps_pkg::PRIME_W-1:0];
                lps_pkg::REG_SWEEP_LENGTH:
                    r_sweep_length <= pwdata[lps_pkg::SLEN_W-1:0];
                lps_pkg::REG_CAPTURE_LENGTH:
                    r_capture_length <= pwdata[lps_pkg::CLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lps_pkg::REG_PRIME_FRAMES:   prdata = 32'(r_prime_frames);
            lps_pkg::REG_SWEEP_LENGTH:   prdata = 32'(r_sweep_length);
            lps_pkg::REG_CAPTURE_LENGTH: prdata = 32'(r_capture_length);
            default:                     prdata = '0;
        endcase
    end

    // ---------------- payload unpack ----------------
    logic [lps_pkg::OP_W-1:0]    in_op;
    logic [lps_pkg::ADDR_W-1:0]  in_addr;
    logic [lps_pkg::FIELD_W-1:0] in_sweep_word;
    logic [lps_pkg::FIELD_W-1:0] in_sample;

    assign in_op         = s_axis_tuser;
    assign in_addr       = s_axis_tdata[17:0];
    assign in_sweep_word = s_axis_tdata[41:18];
    assign in_sample     = s_axis_tdata[65:42];

    // ---------------- control state ----------------
    logic [lps_pkg::MODE_W-1:0]  r_mode, n_mode;
    logic [lps_pkg::PRIME_W-1:0] r_prime_left, n_prime_left;
    lps_pkg::t_spos              r_sweep_pos, n_sweep_pos;
    lps_pkg::t_cpos              r_capture_pos, n_capture_pos;

    // pipeline registers
    logic                        r_s1_vld;
    logic                        r_s1_play;
    logic                        r_s1_rd;
    logic [lps_pkg::MODE_W-1:0]  r_s1_mode;
    logic                        r_out_vld;
    logic [lps_pkg::FIELD_W-1:0] r_out_sample;
    logic [lps_pkg::FIELD_W-1:0] r_out_word;
    logic [lps_pkg::MODE_W-1:0]  r_out_mode;

    logic s1_move;
    logic accept;

    assign s1_move       = r_s1_vld & (~r_out_vld | m_axis_tready);
    assign s_axis_tready = ~r_s1_vld | ~r_out_vld | m_axis_tready;
    assign accept        = s_axis_tvalid & s_axis_tready;

    // effective lengths, clamped to store depth
    lps_pkg::t_spos slen;
    lps_pkg::t_cpos clen;

    assign slen = (32'(r_sweep_length) > 32'(lps_pkg::SWEEP_DEPTH)) ?
                  lps_pkg::t_spos'(lps_pkg::SWEEP_DEPTH) : lps_pkg::t_spos'(r_sweep_length);
    assign clen = (32'(r_capture_length) > 32'(lps_pkg::CAPTURE_DEPTH)) ?
                  lps_pkg::t_cpos'(lps_pkg::CAPTURE_DEPTH) : lps_pkg::t_cpos'(r_capture_length);

    // memory strobes
    logic               sw_we, sw_re, cap_we, cap_re;
    logic               n_play, n_rd;
    lps_pkg::t_sw_idx   sw_idx;
    lps_pkg::t_cap_idx  cap_idx;

    always_comb begin
        logic [lps_pkg::PRIME_W-1:0] p_dec;
        p_dec         = r_prime_left - 1'b1;
        n_mode        = r_mode;
        n_prime_left  = r_prime_left;
        n_sweep_pos   = r_sweep_pos;
        n_capture_pos = r_capture_pos;
        sw_we         = 1'b0;
        sw_re         = 1'b0;
        cap_we        = 1'b0;
        cap_re        = 1'b0;
        n_play        = 1'b0;
        n_rd          = 1'b0;
        sw_idx        = lps_pkg::t_sw_idx'(r_sweep_pos);
        cap_idx       = lps_pkg::t_cap_idx'(r_capture_pos);

        case (in_op)
            lps_pkg::OP_LOAD: begin
                sw_idx = lps_pkg::t_sw_idx'(in_addr);
                sw_we  = 32'(in_addr) < 32'(lps_pkg::SWEEP_DEPTH);
            end
            lps_pkg::OP_ARM: begin
                n_sweep_pos   = '0;
                n_capture_pos = '0;
                n_prime_left  = r_prime_frames;
                n_mode        = lps_pkg::MODE_PRIMING;
            end
            lps_pkg::OP_FRAME: begin
                // zero-frame transitions resolve first, then one frame is spent
                if (n_mode == lps_pkg::MODE_PRIMING && r_prime_left == '0)
                    n_mode = lps_pkg::MODE_EMITTING;
                if (n_mode == lps_pkg::MODE_PRIMING) begin
                    n_prime_left = p_dec;
                    if (p_dec == '0)
                        n_mode = lps_pkg::MODE_EMITTING;
                end else begin
                    if (n_mode == lps_pkg::MODE_EMITTING && r_sweep_pos >= slen)
                        n_mode = lps_pkg::MODE_TRAILING;
                    if (n_mode == lps_pkg::MODE_EMITTING) begin
                        if (r_capture_pos < clen) begin
                            sw_re         = 1'b1;
                            n_play        = 1'b1;
                            cap_we        = 1'b1;
                            n_sweep_pos   = r_sweep_pos + 1'b1;
                            n_capture_pos = r_capture_pos + 1'b1;
                            if (n_sweep_pos >= slen)
                                n_mode = lps_pkg::MODE_TRAILING;
                        end
                    end else if (n_mode == lps_pkg::MODE_TRAILING) begin
                        if (r_capture_pos >= clen) begin
                            n_mode = lps_pkg::MODE_DONE;
                        end else begin
                            cap_we        = 1'b1;
                            n_capture_pos = r_capture_pos + 1'b1;
                            if (n_capture_pos >= clen)
                                n_mode = lps_pkg::MODE_DONE;
                        end
                    end
                end
            end
            lps_pkg::OP_READ: begin
                cap_idx = lps_pkg::t_cap_idx'(in_addr);
                // entries at or past the fill position read as zero; arm resets the position
                n_rd    = (32'(in_addr) < 32'(r_capture_pos)) &&
                          (32'(in_addr) < 32'(lps_pkg::CAPTURE_DEPTH));
                cap_re  = n_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= lps_pkg::MODE_IDLE;
            r_prime_left  <= '0;
            r_sweep_pos   <= '0;
            r_capture_pos <= '0;
        end else if (accept) begin
            r_mode        <= n_mode;
            r_prime_left  <= n_prime_left;
            r_sweep_pos   <= n_sweep_pos;
            r_capture_pos <= n_capture_pos;
        end
    end

    // ---------------- memories ----------------
    lps_pkg::t_sample r_sweep_mem [lps_pkg::SWEEP_DEPTH];
    lps_pkg::t_sample r_cap_mem   [lps_pkg::CAPTURE_DEPTH];
    lps_pkg::t_sample r_sweep_q;
    lps_pkg::t_sample r_cap_q;

    // read data only moves on an accepted read, so it holds while stage 1 stalls
    always_ff @(posedge i_clk) begin
        if (accept && sw_we)
            r_sweep_mem[sw_idx] <= lps_pkg::t_sample'(in_sweep_word);
        if (accept && sw_re)
            r_sweep_q <= r_sweep_mem[sw_idx];
    end

    always_ff @(posedge i_clk) begin
        if (accept && cap_we)
            r_cap_mem[cap_idx] <= lps_pkg::t_sample'(in_sample);
        if (accept && cap_re)
            r_cap_q <= r_cap_mem[cap_idx];
    end

    // ---------------- stage 1 and output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_play <= n_play;
            r_s1_rd   <= n_rd;
            r_s1_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_move) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_sample <= r_s1_play ? lps_pkg::FIELD_W'(r_sweep_q) : '0;
            r_out_word   <= r_s1_rd ? lps_pkg::FIELD_W'(r_cap_q) : '0;
            r_out_mode   <= r_s1_mode;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'b0, r_out_mode, r_out_word, r_out_sample};

endmodule

`default_nettype wire
